@@ src/crc16fa_pkg.sv @@
// ----------------------------------------------------------------------------
// crc16fa_pkg
// Shared types, codes and the byte-wide CRC-16 update for the frame
// append/check block.
// ----------------------------------------------------------------------------
package crc16fa_pkg;

	// CRC-16 (reflected, poly 0x8005 -> 0xA001), init all ones, no final xor
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Operation field
	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_CHECK  = 1'b1;

	// Job codes passed from front to back
	localparam logic [1:0] JOB_ECHO    = 2'd0;  // echo byte only
	localparam logic [1:0] JOB_APPEND  = 2'd1;  // echo byte, then CRC low, CRC high
	localparam logic [1:0] JOB_VERDICT = 2'd2;  // check verdict only

	// Result kinds
	localparam logic [1:0] KIND_DATA    = 2'd0;
	localparam logic [1:0] KIND_CRC     = 2'd1;
	localparam logic [1:0] KIND_VERDICT = 2'd2;

	// Result phase within one job
	localparam logic [1:0] PH_FIRST = 2'd0;
	localparam logic [1:0] PH_LOW   = 2'd1;
	localparam logic [1:0] PH_HIGH  = 2'd2;

	typedef struct packed {
		logic [1:0]  code;
		logic [7:0]  data;
		logic [15:0] crc;
		logic        good;
	} job_t;

	// Eight reflected shift steps for one byte
	function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
		input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

@@ src/crc16fa_front.sv @@
// ----------------------------------------------------------------------------
// crc16fa_front
// Accepts frame bytes, runs the CRC and byte count, and turns each item
// into a job for the back end (or drops it when it yields no result).
// ----------------------------------------------------------------------------
module crc16fa_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          data_byte,
	input  logic                end_of_frame,
	input  logic                operation,
	input  logic                q_full,
	output logic                push,
	output crc16fa_pkg::job_t   push_job
);
	import crc16fa_pkg::*;

	logic [15:0] crc_q;
	logic [1:0]  bytes_seen_q;
	logic        accept;
	logic [15:0] crc_next;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;
	assign crc_next = crc_feed(crc_q, data_byte);

	// check bytes before the last one produce nothing
	assign push = accept && ((operation == OP_APPEND) || end_of_frame);

	// classify the item
	always_comb begin
		push_job.data = data_byte;
		push_job.crc  = crc_next;
		push_job.good = (bytes_seen_q != 2'd0) && (crc_next == 16'h0000);
		if (operation == OP_CHECK) begin
			push_job.code = JOB_VERDICT;
		end else if (end_of_frame) begin
			push_job.code = JOB_APPEND;
		end else begin
			push_job.code = JOB_ECHO;
		end
	end

	// running CRC and saturating byte count, cleared at end of frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q        <= CRC_INIT;
			bytes_seen_q <= 2'd0;
		end else if (accept) begin
			if (end_of_frame) begin
				crc_q        <= CRC_INIT;
				bytes_seen_q <= 2'd0;
			end else begin
				crc_q <= crc_next;
				if (bytes_seen_q != 2'd3) begin
					bytes_seen_q <= bytes_seen_q + 2'd1;
				end
			end
		end
	end

endmodule

@@ src/crc16fa_queue.sv @@
// ----------------------------------------------------------------------------
// crc16fa_queue
// Small job FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module crc16fa_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  crc16fa_pkg::job_t   push_job,
	output logic                full,
	input  logic                pop,
	output logic                empty,
	output crc16fa_pkg::job_t   head_job
);
	import crc16fa_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_job = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ src/crc16fa_back.sv @@
// ----------------------------------------------------------------------------
// crc16fa_back
// Expands each job into its results (one, or three for an appended CRC)
// and holds them in the output register.
// ----------------------------------------------------------------------------
module crc16fa_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  crc16fa_pkg::job_t   head_job,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          out_byte,
	output logic [1:0]          item_kind,
	output logic                crc_good,
	output logic [15:0]         crc_value,
	output logic                last_of_run
);
	import crc16fa_pkg::*;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic [1:0]  item_kind_q;
	logic        crc_good_q;
	logic [15:0] crc_value_q;
	logic        last_q;
	logic [1:0]  phase_q;

	logic        load;
	logic [7:0]  res_byte;
	logic [1:0]  res_kind;
	logic        res_good;
	logic        res_last;

	assign load = !q_empty && (!out_valid_q || !out_stall);
	assign pop  = load && res_last;

	// result for the current job and phase
	always_comb begin
		res_byte = head_job.data;
		res_kind = KIND_DATA;
		res_good = 1'b0;
		res_last = 1'b1;
		unique case (head_job.code)
			JOB_ECHO: begin
				res_last = 1'b1;
			end
			JOB_APPEND: begin
				case (phase_q)
					PH_FIRST: begin
						res_last = 1'b0;
					end
					PH_LOW: begin
						res_byte = head_job.crc[7:0];
						res_kind = KIND_CRC;
						res_last = 1'b0;
					end
					default: begin
						res_byte = head_job.crc[15:8];
						res_kind = KIND_CRC;
						res_last = 1'b1;
					end
				endcase
			end
			JOB_VERDICT: begin
				res_byte = 8'h00;
				res_kind = KIND_VERDICT;
				res_good = head_job.good;
			end
			default: begin
				res_last = 1'b1;
			end
		endcase
	end

	// phase sequencer and output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= PH_FIRST;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				phase_q     <= res_last ? PH_FIRST : phase_q + 2'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q  <= res_byte;
			item_kind_q <= res_kind;
			crc_good_q  <= res_good;
			crc_value_q <= head_job.crc;
			last_q      <= res_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign item_kind   = item_kind_q;
	assign crc_good    = crc_good_q;
	assign crc_value   = crc_value_q;
	assign last_of_run = last_q;

endmodule

@@ src/crc16_frame_append_check.sv @@
// ----------------------------------------------------------------------------
// crc16_frame_append_check
// CRC-16/MODBUS frame appender and checker, one byte per item.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle while in_stall is low. The front end updates
// the CRC (eight unrolled shift steps) and queues a job; the back end emits one
// result per cycle from its output register while out_stall is low. Append
// frames echo each byte and follow the final byte with the CRC low then high
// byte; check frames give one verdict on the final byte, with crc_value holding
// the residue. Sustained rate is one item per cycle, except that a final append
// byte yields three results, so the output side sets the pace there: in_stall
// rises only when the QUEUE_DEPTH job queue is full.
// ----------------------------------------------------------------------------
module crc16_frame_append_check #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_frame,
	input  logic        operation,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic [1:0]  item_kind,
	output logic        crc_good,
	output logic [15:0] crc_value,
	output logic        last_of_run
);
	import crc16fa_pkg::*;

	logic q_full;
	logic q_empty;
	logic push;
	logic pop;
	job_t push_job;
	job_t head_job;

	// byte intake and classification
	crc16fa_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.end_of_frame (end_of_frame),
		.operation    (operation),
		.q_full       (q_full),
		.push         (push),
		.push_job     (push_job)
	);

	// job queue
	crc16fa_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.head_job (head_job)
	);

	// result sequencing
	crc16fa_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.head_job    (head_job),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.item_kind   (item_kind),
		.crc_good    (crc_good),
		.crc_value   (crc_value),
		.last_of_run (last_of_run)
	);

endmodule
